// ----- src/stack_machine_executor_top_defines.svh -----
// Assertion macros for the stack machine executor modules, used by the back end.
`ifndef STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SME_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sme assertion failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SME_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sme assertion failed");
`else
`define SME_ASSERT_NOW(lbl, ante, cons)
`define SME_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- src/sme_pkg.sv -----
// Types and constants shared by the stack machine executor modules.
package sme_pkg;

	localparam int INSTR_W  = 8;
	localparam int OPND_W   = 5;
	localparam int DATA_W   = 32;
	localparam int LEN_W    = 9;
	localparam int PC_OUT_W = 9;
	localparam int DEPTH_W  = 8;
	localparam int STATUS_W = 3;

	localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

	// status / halt codes
	localparam logic [STATUS_W-1:0] ST_RUN      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_END      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVF      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNF      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_ADD  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_SUB  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_JZ_EMPTY = 3'd6;
	localparam logic [STATUS_W-1:0] ST_BAD_SWAP = 3'd7;

	typedef enum logic [2:0] {
		OP_NOP  = 3'd0,
		OP_PUSH = 3'd1,
		OP_POP  = 3'd2,
		OP_ADD  = 3'd3,
		OP_SUB  = 3'd4,
		OP_JZ   = 3'd5,
		OP_JMP  = 3'd6,
		OP_SWAP = 3'd7
	} opcode_t;

	// decoded instruction word, front to back
	typedef struct packed {
		opcode_t           op;
		logic [OPND_W-1:0] operand;
	} item_t;

	// one result word, back to output register
	typedef struct packed {
		logic [PC_OUT_W-1:0] next_pc;
		logic [DATA_W-1:0]   top_value;
		logic [DEPTH_W-1:0]  stack_depth;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

// ----- src/sme_front.sv -----
// Front end: accepts instruction words, decodes them and queues them for the back end.
module sme_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         instr_valid,
	output logic                         instr_stall,
	input  logic [sme_pkg::INSTR_W-1:0]  instruction,
	output logic                         q_valid,
	output sme_pkg::item_t               q_item,
	input  logic                         q_pop
);

	sme_pkg::item_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           push;
	sme_pkg::item_t dec;

	// decode opcode and operand fields
	always_comb begin
		dec.op      = sme_pkg::opcode_t'(instruction[sme_pkg::INSTR_W-1:sme_pkg::OPND_W]);
		dec.operand = instruction[sme_pkg::OPND_W-1:0];
	end

	assign instr_stall = (fill_q == 2'd2);
	assign push        = instr_valid && !instr_stall;
	assign q_valid     = (fill_q != 2'd0);
	assign q_item      = fifo_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- src/sme_back.sv -----
// Back end: executes decoded instructions against the stack memory and machine state.
`include "stack_machine_executor_top_defines.svh"
module sme_back #(
	parameter int STACK_DEPTH = 128,
	parameter int MAX_PROGRAM = 256,
	localparam int PW = $clog2(MAX_PROGRAM + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [PW-1:0]       eff_len,
	input  logic                q_valid,
	input  sme_pkg::item_t      q_item,
	output logic                q_pop,
	input  logic                res_ready,
	output logic                res_valid,
	output sme_pkg::res_t       res
);

	localparam int AW   = $clog2(STACK_DEPTH);
	localparam int CW   = $clog2(STACK_DEPTH + 1);
	localparam int CMPW = (CW > sme_pkg::OPND_W) ? CW : sme_pkg::OPND_W;
	localparam int DW   = sme_pkg::DATA_W;

	typedef enum logic {
		PH_ISSUE,
		PH_EXEC
	} phase_t;

	phase_t                       state_q;
	sme_pkg::item_t               ex_q;
	logic [CW-1:0]                cnt_q;
	logic [PW-1:0]                pc_q;
	logic [sme_pkg::STATUS_W-1:0] halt_q;
	logic [DW-1:0]                top_q;

	// entries below the top; the top itself lives in top_q
	logic [DW-1:0] mem [STACK_DEPTH];
	logic [DW-1:0] rd_q;
	logic [AW-1:0] raddr;

	logic                         commit;
	logic                         ignore;
	logic                         full;
	logic                         op_is_top;
	logic                         opnd_oob;
	logic [PW-1:0]                pc_inc;
	logic [AW-1:0]                top_idx;
	logic [DW-1:0]                src;
	logic [CW-1:0]                n_cnt;
	logic [PW-1:0]                n_pc;
	logic [sme_pkg::STATUS_W-1:0] n_halt;
	logic [DW-1:0]                n_top;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic                         err;

	// read address: POP reads the entry below the top, others the indexed entry
	assign q_pop = (state_q == PH_ISSUE) && q_valid;
	always_comb begin
		if (q_item.op == sme_pkg::OP_POP) begin
			raddr = AW'(cnt_q - CW'(2));
		end else begin
			raddr = AW'(q_item.operand);
		end
	end

	// stack memory: read on issue, write on commit
	always_ff @(posedge clk) begin
		if (commit && mem_we) begin
			mem[mem_waddr] <= top_q;
		end
		if (q_pop) begin
			rd_q <= mem[raddr];
		end
	end

	// operand checks
	assign commit    = (state_q == PH_EXEC) && res_ready;
	assign ignore    = (halt_q != sme_pkg::ST_RUN) || (pc_q >= eff_len);
	assign full      = (cnt_q == CW'(STACK_DEPTH));
	assign op_is_top = (CMPW'(ex_q.operand) == CMPW'(cnt_q - CW'(1)));
	assign opnd_oob  = (CMPW'(ex_q.operand) >= CMPW'(cnt_q));
	assign pc_inc    = pc_q + PW'(1);
	assign top_idx   = AW'(cnt_q - CW'(1));
	assign src       = op_is_top ? top_q : rd_q;

	// next machine state
	always_comb begin
		n_cnt     = cnt_q;
		n_pc      = pc_q;
		n_halt    = halt_q;
		n_top     = top_q;
		mem_we    = 1'b0;
		mem_waddr = top_idx;
		if (!ignore) begin
			case (ex_q.op)
				sme_pkg::OP_NOP: begin
					n_pc = pc_inc;
				end
				sme_pkg::OP_PUSH: begin
					if (full) begin
						n_halt = sme_pkg::ST_OVF;
					end else begin
						mem_we = (cnt_q != '0);
						n_top  = DW'(ex_q.operand);
						n_cnt  = cnt_q + CW'(1);
						n_pc   = pc_inc;
					end
				end
				sme_pkg::OP_POP: begin
					if (cnt_q == '0) begin
						n_halt = sme_pkg::ST_UNF;
					end else begin
						n_top = rd_q;
						n_cnt = cnt_q - CW'(1);
						n_pc  = pc_inc;
					end
				end
				sme_pkg::OP_ADD: begin
					if (cnt_q < CW'(2) || opnd_oob) begin
						n_halt = sme_pkg::ST_BAD_ADD;
					end else begin
						n_top = top_q + src;
						n_pc  = pc_inc;
					end
				end
				sme_pkg::OP_SUB: begin
					if (cnt_q < CW'(2) || opnd_oob) begin
						n_halt = sme_pkg::ST_BAD_SUB;
					end else begin
						n_top = top_q - src;
						n_pc  = pc_inc;
					end
				end
				sme_pkg::OP_JZ: begin
					if (cnt_q == '0) begin
						n_halt = sme_pkg::ST_JZ_EMPTY;
					end else if (top_q == '0) begin
						n_pc = PW'(ex_q.operand);
					end else begin
						n_pc = pc_inc;
					end
				end
				sme_pkg::OP_JMP: begin
					n_pc = PW'(ex_q.operand);
				end
				sme_pkg::OP_SWAP: begin
					if (cnt_q == '0 || opnd_oob) begin
						n_halt = sme_pkg::ST_BAD_SWAP;
					end else begin
						if (!op_is_top) begin
							mem_we    = 1'b1;
							mem_waddr = AW'(ex_q.operand);
							n_top     = rd_q;
						end
						n_pc = pc_inc;
					end
				end
				default: begin
					n_pc = pc_q;
				end
			endcase
		end
	end

	assign err = (halt_q == sme_pkg::ST_RUN) && (n_halt != sme_pkg::ST_RUN);

	// result word from the state after the step
	always_comb begin
		res.next_pc     = sme_pkg::PC_OUT_W'(n_pc);
		res.top_value   = (n_cnt == '0) ? '0 : n_top;
		res.stack_depth = sme_pkg::DEPTH_W'(n_cnt);
		if (n_halt != sme_pkg::ST_RUN) begin
			res.status = n_halt;
		end else if (n_pc >= eff_len) begin
			res.status = sme_pkg::ST_END;
		end else begin
			res.status = sme_pkg::ST_RUN;
		end
	end
	assign res_valid = commit;

	// issue/execute sequencer and machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_ISSUE;
			cnt_q   <= '0;
			pc_q    <= '0;
			halt_q  <= sme_pkg::ST_RUN;
			top_q   <= '0;
			ex_q    <= '0;
		end else begin
			case (state_q)
				PH_ISSUE: begin
					if (q_valid) begin
						ex_q    <= q_item;
						state_q <= PH_EXEC;
					end
				end
				PH_EXEC: begin
					if (commit) begin
						cnt_q   <= n_cnt;
						pc_q    <= n_pc;
						halt_q  <= n_halt;
						top_q   <= n_top;
						state_q <= PH_ISSUE;
					end
				end
				default: state_q <= PH_ISSUE;
			endcase
		end
	end

	`SME_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(STACK_DEPTH))
	`SME_ASSERT_NXT(a_halt_sticky, halt_q != sme_pkg::ST_RUN, halt_q == $past(halt_q))
	`SME_ASSERT_NXT(a_err_freeze, commit && err, pc_q == $past(pc_q) && cnt_q == $past(cnt_q))

endmodule

// ----- src/stack_machine_executor_top.sv -----
// Stack machine executor: one instruction word in, one result word out.
// A result passes the instruction queue, the issue register (ex_q), the execute phase and the output register.
// The back end alternates issue and execute and takes no new instruction until the last one has executed,
// set by the issue/execute pair around the single stack memory port (read on issue, write on execute).
// A two-entry queue and an output register decouple input and output stalls.
// Reset clears pc, depth and halt code and sets program_length to 256; no clearing pass.
module stack_machine_executor_top #(
	parameter int STACK_DEPTH = 128,
	parameter int MAX_PROGRAM = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          program_length_we,
	input  logic [sme_pkg::LEN_W-1:0]     program_length_wdata,
	input  logic                          instr_valid,
	output logic                          instr_stall,
	input  logic [sme_pkg::INSTR_W-1:0]   instruction,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [sme_pkg::PC_OUT_W-1:0]  next_pc,
	output logic signed [sme_pkg::DATA_W-1:0] top_value,
	output logic [sme_pkg::DEPTH_W-1:0]   stack_depth,
	output logic [sme_pkg::STATUS_W-1:0]  status
);

	localparam int PW = $clog2(MAX_PROGRAM + 1);

	logic [sme_pkg::LEN_W-1:0] len_q;
	logic [PW-1:0]             eff_len;
	logic                      q_valid;
	sme_pkg::item_t            q_item;
	logic                      q_pop;
	logic                      res_ready;
	logic                      res_valid;
	sme_pkg::res_t             res;
	logic                      out_valid_q;
	sme_pkg::res_t             out_q;

	// program length register; its effective value is clamped to MAX_PROGRAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= sme_pkg::LEN_RESET;
		end else if (program_length_we) begin
			len_q <= program_length_wdata;
		end
	end
	assign eff_len = (len_q > sme_pkg::LEN_W'(MAX_PROGRAM)) ? PW'(MAX_PROGRAM) : PW'(len_q);

	sme_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.instruction (instruction),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	sme_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.MAX_PROGRAM (MAX_PROGRAM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_len   (eff_len),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register
	assign res_ready = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign next_pc      = out_q.next_pc;
	assign top_value    = $signed(out_q.top_value);
	assign stack_depth  = out_q.stack_depth;
	assign status       = out_q.status;

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for the stack machine executor: directed table, random programs, halt/end tail.
`timescale 1ns / 100ps

module tb;

	localparam int STK_DEPTH    = 128;
	localparam int MAX_PROG     = 256;
	localparam int PC_FOLD      = 200;  // jump back before the pc runs off the program
	localparam int IDLE_PAD     = 4;    // settle cycles before a register write
	localparam int HOLD_CYCLES  = 60;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 1350;

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		logic [sme_pkg::INSTR_W-1:0] word;
		logic                        typed;
		sme_pkg::res_t               want;
	} dir_row_t;

	localparam int N_DIR = 19;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{{sme_pkg::OP_NOP,  5'd0},  1'b1, '{9'd1, 32'd0,  8'd0, sme_pkg::ST_RUN}},
		'{{sme_pkg::OP_PUSH, 5'd31}, 1'b1, '{9'd2, 32'd31, 8'd1, sme_pkg::ST_RUN}},
		'{{sme_pkg::OP_PUSH, 5'd0},  1'b1, '{9'd3, 32'd0,  8'd2, sme_pkg::ST_RUN}},
		'{{sme_pkg::OP_ADD,  5'd0},  1'b0, '0},
		'{{sme_pkg::OP_PUSH, 5'd1},  1'b0, '0},
		'{{sme_pkg::OP_SUB,  5'd0},  1'b0, '0},  // goes negative
		'{{sme_pkg::OP_SWAP, 5'd0},  1'b0, '0},
		'{{sme_pkg::OP_SWAP, 5'd2},  1'b0, '0},  // top with itself
		'{{sme_pkg::OP_JZ,   5'd31}, 1'b0, '0},  // top nonzero, falls through
		'{{sme_pkg::OP_ADD,  5'd2},  1'b0, '0},  // top plus itself
		'{{sme_pkg::OP_POP,  5'd31}, 1'b0, '0},
		'{{sme_pkg::OP_PUSH, 5'd0},  1'b0, '0},
		'{{sme_pkg::OP_JZ,   5'd20}, 1'b0, '0},  // top zero, taken
		'{{sme_pkg::OP_JMP,  5'd31}, 1'b0, '0},
		'{{sme_pkg::OP_NOP,  5'd31}, 1'b0, '0},
		'{{sme_pkg::OP_SUB,  5'd1},  1'b0, '0},
		'{{sme_pkg::OP_JMP,  5'd0},  1'b0, '0},
		'{{sme_pkg::OP_SWAP, 5'd1},  1'b0, '0},
		'{{sme_pkg::OP_POP,  5'd0},  1'b0, '0}
	};

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 program_length_we;
	logic [sme_pkg::LEN_W-1:0]            program_length_wdata;
	logic                                 instr_valid;
	logic                                 instr_stall;
	logic [sme_pkg::INSTR_W-1:0]          instruction;
	logic                                 result_valid;
	logic                                 result_stall;
	logic [sme_pkg::PC_OUT_W-1:0]         next_pc;
	logic signed [sme_pkg::DATA_W-1:0]    top_value;
	logic [sme_pkg::DEPTH_W-1:0]          stack_depth;
	logic [sme_pkg::STATUS_W-1:0]         status;

	// shadow machine state
	logic [sme_pkg::DATA_W-1:0]   shadow_stack [STK_DEPTH];
	int                           shadow_count;
	int                           shadow_pc;
	int                           shadow_len;
	logic [sme_pkg::STATUS_W-1:0] shadow_halt;

	sme_pkg::res_t states_due [$];
	int   error_count  = 0;
	int   sent_words   = 0;
	int   idle_pct     = 32;
	bit   hold_req     = 1'b0;
	int   quiet_cycles = 0;

	stack_machine_executor_top #(
		.STACK_DEPTH(STK_DEPTH),
		.MAX_PROGRAM(MAX_PROG)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.program_length_we(program_length_we),
		.program_length_wdata(program_length_wdata),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.instruction(instruction),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.next_pc(next_pc),
		.top_value(top_value),
		.stack_depth(stack_depth),
		.status(status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int eff_len();
		return (shadow_len > MAX_PROG) ? MAX_PROG : shadow_len;
	endfunction

	function automatic bit machine_live();
		return shadow_halt == sme_pkg::ST_RUN && shadow_pc < eff_len();
	endfunction

	function automatic logic [sme_pkg::OPND_W-1:0] rand_opnd();
		return sme_pkg::OPND_W'($urandom_range(31));
	endfunction

	// advance the shadow machine by one instruction, return the state it reports
	function automatic sme_pkg::res_t execute_instr(input logic [sme_pkg::INSTR_W-1:0] w);
		sme_pkg::opcode_t           op;
		int                         opnd;
		int                         t;
		logic [sme_pkg::DATA_W-1:0] tmp;
		sme_pkg::res_t              r;
		op = sme_pkg::opcode_t'(w[7:5]);
		opnd = int'(w[4:0]);
		t = shadow_count - 1;
		if (machine_live()) begin
			case (op)
				sme_pkg::OP_NOP: shadow_pc++;
				sme_pkg::OP_PUSH: if (shadow_count >= STK_DEPTH) begin
					shadow_halt = sme_pkg::ST_OVF;
				end else begin
					shadow_stack[shadow_count] = sme_pkg::DATA_W'(opnd);
					shadow_count++;
					shadow_pc++;
				end
				sme_pkg::OP_POP: if (shadow_count == 0) begin
					shadow_halt = sme_pkg::ST_UNF;
				end else begin
					shadow_count--;
					shadow_pc++;
				end
				sme_pkg::OP_ADD, sme_pkg::OP_SUB:
				if (shadow_count < 2 || opnd >= shadow_count) begin
					shadow_halt = (op == sme_pkg::OP_ADD) ? sme_pkg::ST_BAD_ADD
						: sme_pkg::ST_BAD_SUB;
				end else begin
					if (op == sme_pkg::OP_ADD)
						shadow_stack[t] = shadow_stack[t] + shadow_stack[opnd];
					else
						shadow_stack[t] = shadow_stack[t] - shadow_stack[opnd];
					shadow_pc++;
				end
				sme_pkg::OP_JZ: if (shadow_count == 0) begin
					shadow_halt = sme_pkg::ST_JZ_EMPTY;
				end else if (shadow_stack[t] == '0) begin
					shadow_pc = opnd;
				end else begin
					shadow_pc++;
				end
				sme_pkg::OP_JMP: shadow_pc = opnd;
				default: if (shadow_count == 0 || opnd >= shadow_count) begin
					shadow_halt = sme_pkg::ST_BAD_SWAP;
				end else begin
					tmp = shadow_stack[t];
					shadow_stack[t] = shadow_stack[opnd];
					shadow_stack[opnd] = tmp;
					shadow_pc++;
				end
			endcase
		end
		r.next_pc = sme_pkg::PC_OUT_W'(shadow_pc);
		r.top_value = (shadow_count == 0) ? '0 : shadow_stack[shadow_count - 1];
		r.stack_depth = sme_pkg::DEPTH_W'(shadow_count);
		if (shadow_halt != sme_pkg::ST_RUN)
			r.status = shadow_halt;
		else if (shadow_pc >= eff_len())
			r.status = sme_pkg::ST_END;
		else
			r.status = sme_pkg::ST_RUN;
		return r;
	endfunction

	// random instruction that never trips a fatal condition
	function automatic logic [sme_pkg::INSTR_W-1:0] pick_safe_word(input int push_pct);
		sme_pkg::opcode_t           op;
		int                         lim;
		logic [sme_pkg::OPND_W-1:0] opnd;
		op = ($urandom_range(99) < push_pct) ? sme_pkg::OP_PUSH
			: sme_pkg::opcode_t'($urandom_range(7));
		opnd = rand_opnd();
		lim = (shadow_count < 32) ? shadow_count : 32;
		case (op)
			sme_pkg::OP_PUSH: if (shadow_count >= STK_DEPTH) op = sme_pkg::OP_POP;
			sme_pkg::OP_POP: if (shadow_count == 0) op = sme_pkg::OP_PUSH;
			sme_pkg::OP_ADD, sme_pkg::OP_SUB: if (shadow_count < 2) begin
				op = sme_pkg::OP_PUSH;
			end else if ($urandom_range(3) == 0) begin
				opnd = sme_pkg::OPND_W'(lim - 1);  // top itself when shallow
			end else begin
				opnd = sme_pkg::OPND_W'($urandom_range(lim - 1));
			end
			sme_pkg::OP_JZ: if (shadow_count == 0) op = sme_pkg::OP_PUSH;
			sme_pkg::OP_SWAP: if (shadow_count == 0) begin
				op = sme_pkg::OP_PUSH;
			end else begin
				opnd = sme_pkg::OPND_W'($urandom_range(lim - 1));
			end
			default: ;
		endcase
		return {op, opnd};
	endfunction

	// offer one word, with a random gap first; valid stays high after acceptance
	task automatic send_word(input logic [sme_pkg::INSTR_W-1:0] w,
			input bit use_typed = 1'b0, input sme_pkg::res_t typed = '0);
		sme_pkg::res_t r;
		if ($urandom_range(99) < idle_pct) begin
			instr_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		instr_valid <= 1'b1;
		instruction <= w;
		@(posedge clk);
		while (instr_stall) @(posedge clk);
		sent_words++;
		r = execute_instr(w);
		states_due.push_back(use_typed ? typed : r);
	endtask

	// keep the pc clear of the program end while the machine runs
	task automatic issue_word(input logic [sme_pkg::INSTR_W-1:0] w);
		if (machine_live() && shadow_pc >= PC_FOLD)
			send_word({sme_pkg::OP_JMP, rand_opnd()});
		send_word(w);
	endtask

	task automatic set_depth(input int tgt);
		while (shadow_count > tgt) issue_word({sme_pkg::OP_POP, rand_opnd()});
		while (shadow_count < tgt) issue_word({sme_pkg::OP_PUSH, rand_opnd()});
	endtask

	// register write, only with the machine drained
	task automatic set_program_length(input logic [sme_pkg::LEN_W-1:0] v);
		instr_valid <= 1'b0;
		while (states_due.size() != 0) @(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
		program_length_we <= 1'b1;
		program_length_wdata <= v;
		@(posedge clk);
		program_length_we <= 1'b0;
		shadow_len = int'(v);
	endtask

	// double a one up to the signed extremes
	task automatic doubling_run();
		int k;
		while (machine_live() && shadow_count > 28)
			issue_word({sme_pkg::OP_POP, rand_opnd()});
		issue_word({sme_pkg::OP_PUSH, 5'd1});
		issue_word({sme_pkg::OP_PUSH, 5'd1});
		k = shadow_count - 1;
		repeat (31) issue_word({sme_pkg::OP_ADD, sme_pkg::OPND_W'(k)});
		issue_word({sme_pkg::OP_SUB, sme_pkg::OPND_W'(k - 1)});
	endtask

	task automatic check_result();
		sme_pkg::res_t want;
		if (states_due.size() == 0) begin
			$error("result word with nothing pending: next_pc %0d status %0d", next_pc, status);
			error_count++;
		end else begin
			want = states_due.pop_front();
			if (next_pc !== want.next_pc) begin
				$error("next_pc: expected %0d, got %0d", want.next_pc, next_pc);
				error_count++;
			end
			if (top_value !== want.top_value) begin
				$error("top_value: expected %0d, got %0d", $signed(want.top_value), top_value);
				error_count++;
			end
			if (stack_depth !== want.stack_depth) begin
				$error("stack_depth: expected %0d, got %0d", want.stack_depth, stack_depth);
				error_count++;
			end
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				error_count++;
			end
		end
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : result_side
		int hold_left;
		hold_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) check_result();
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((instr_valid && !instr_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int                        seg;
		int                        n;
		int                        push_pct;
		int                        tgt;
		logic [sme_pkg::LEN_W-1:0] plen;
		logic [2:0]                tail_kind;
		sme_pkg::opcode_t          op;
		arst_n <= 1'b0;
		program_length_we <= 1'b0;
		program_length_wdata <= sme_pkg::LEN_RESET;
		instr_valid <= 1'b0;
		instruction <= '0;
		shadow_count = 0;
		shadow_pc = 0;
		shadow_len = int'(sme_pkg::LEN_RESET);
		shadow_halt = sme_pkg::ST_RUN;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_DIR; i++)
			send_word(DIR_ROWS[i].word, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		// program end: reached, ignored, length zero, then resumed by a large length
		set_program_length(sme_pkg::LEN_W'(shadow_pc + 2));
		repeat (3) send_word({sme_pkg::OP_NOP, rand_opnd()});
		set_program_length('0);
		send_word({sme_pkg::OP_PUSH, rand_opnd()});
		set_program_length('1);
		send_word({sme_pkg::OP_NOP, rand_opnd()});

		// random programs, one length per segment
		seg = 0;
		while (sent_words < RANDOM_WORDS) begin
			case ($urandom_range(7))
				0: plen = '0;
				1: plen = sme_pkg::LEN_W'(shadow_pc + $urandom_range(1, 6));
				2: plen = sme_pkg::LEN_W'($urandom_range(511));
				3: plen = '1;
				4: plen = sme_pkg::LEN_W'(MAX_PROG - 1);
				default: plen = sme_pkg::LEN_RESET;
			endcase
			set_program_length(plen);
			idle_pct = (seg == 1 || (seg >= 3 && seg < 6)) ? 0 : 32;
			if (seg == 1) hold_req = 1'b1;
			push_pct = ($urandom_range(3) == 0) ? 70 : 15;
			n = $urandom_range(80, 30);
			repeat (n) begin
				if (machine_live() && $urandom_range(59) == 0)
					doubling_run();
				else
					issue_word(pick_safe_word(push_pct));
			end
			seg++;
		end

		// tail: one fatal condition, or the run to the last address
		idle_pct = 32;
		set_program_length(sme_pkg::LEN_RESET);
		tail_kind = 3'($urandom_range(sme_pkg::ST_BAD_SWAP, sme_pkg::ST_END));
		case (tail_kind)
			sme_pkg::ST_END: begin
				set_program_length('1);
				while (shadow_pc < MAX_PROG) send_word({sme_pkg::OP_NOP, rand_opnd()});
			end
			sme_pkg::ST_OVF: begin
				set_depth(STK_DEPTH);
				issue_word({sme_pkg::OP_PUSH, rand_opnd()});
			end
			sme_pkg::ST_UNF: begin
				set_depth(0);
				issue_word({sme_pkg::OP_POP, rand_opnd()});
			end
			sme_pkg::ST_BAD_ADD, sme_pkg::ST_BAD_SUB: begin
				op = (tail_kind == sme_pkg::ST_BAD_ADD) ? sme_pkg::OP_ADD : sme_pkg::OP_SUB;
				if ($urandom_range(1)) begin
					// too few entries
					set_depth($urandom_range(1));
					issue_word({op, rand_opnd()});
				end else begin
					// index past the depth
					set_depth($urandom_range(20, 2));
					issue_word({op, sme_pkg::OPND_W'($urandom_range(31, shadow_count))});
				end
			end
			sme_pkg::ST_JZ_EMPTY: begin
				set_depth(0);
				issue_word({sme_pkg::OP_JZ, rand_opnd()});
			end
			default: begin
				tgt = $urandom_range(1) ? 0 : $urandom_range(20, 1);
				set_depth(tgt);
				issue_word({sme_pkg::OP_SWAP, sme_pkg::OPND_W'($urandom_range(31, tgt))});
			end
		endcase

		// halt and end both hold across more words and a register write
		repeat (4) send_word(sme_pkg::INSTR_W'($urandom_range(255)));
		set_program_length(sme_pkg::LEN_W'($urandom_range(511)));
		repeat (4) send_word(sme_pkg::INSTR_W'($urandom_range(255)));

		instr_valid <= 1'b0;
		while (states_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
